// ===== hw/rtl/cht_pkg.sv =====
// Package: shared constants and types for the chained hash table engine.
package cht_pkg;
   localparam int NumBucketsDefault  = 64;
   localparam int PoolEntriesDefault = 64;
   localparam int MaxKeyBytesDefault = 16;
   localparam logic [6:0] BucketCountReset = 7'd53;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_ACCESS = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key_low;
      logic [63:0] key_high;
      logic [4:0]  key_length;
      logic signed [31:0] value_in;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic signed [31:0] value_out;
   } rsp_type;
endpackage

// ===== hw/rtl/cht_req_if.sv =====
// Interface: request channel carrying one table operation per beat.
interface cht_req_if import cht_pkg::*; ();
   logic         valid;
   logic         ready;
   req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/cht_rsp_if.sv =====
// Interface: response channel carrying one status/value beat.
interface cht_rsp_if import cht_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/chained_hash_table_engine_top.sv =====
// Top level: chained hash table engine with node pool and bucket chains.
// Flow: per key byte a multiply step and a subtract loop reduce the hash; then a lookup
//   reads the bucket head and compares chain nodes in turn, with a delete step on delete,
//   and an insert scans for the first free node (reporting full when none is free).
// One request in flight; the result register lets the next beat be taken while a result
//   waits. After a synchronous active-high reset, all bucket heads are cleared first.
module chained_hash_table_engine_top import cht_pkg::*; #(
   parameter int NUM_BUCKETS   = NumBucketsDefault,
   parameter int POOL_ENTRIES  = PoolEntriesDefault,
   parameter int MAX_KEY_BYTES = MaxKeyBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   cht_req_if.sink    req,
   cht_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data
);
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int NW = $clog2(POOL_ENTRIES + 1);
   localparam int PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int HW = BW + 1;
   localparam int MW = HW + 8;
   localparam logic [NW-1:0] NoNode = NW'(POOL_ENTRIES);

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_MUL = 4'd2, S_MOD = 4'd3,
      S_HEAD = 4'd4, S_HEADW = 4'd5, S_NODE = 4'd6, S_CMP = 4'd7, S_SCAN = 4'd8,
      S_INS = 4'd9, S_DEL = 4'd10, S_OUT = 4'd11, S_HEADR = 4'd12;

   logic [NW-1:0] heads [NUM_BUCKETS];
   logic [63:0]   n_lo  [POOL_ENTRIES];
   logic [63:0]   n_hi  [POOL_ENTRIES];
   logic [4:0]    n_len [POOL_ENTRIES];
   logic [31:0]   n_val [POOL_ENTRIES];
   logic [NW-1:0] n_lnk [POOL_ENTRIES];
   logic [POOL_ENTRIES-1:0] free_ff;

   logic [3:0]  state_ff;
   logic [6:0]  bcnt_ff;
   logic [1:0]  op_ff;
   logic [63:0] lo_ff, hi_ff;
   logic [4:0]  len_ff, idx_ff;
   logic [31:0] val_ff;
   logic [HW-1:0] mod_ff;
   logic [MW-1:0] h_ff;
   logic [BW-1:0] bkt_ff;
   logic [NW-1:0] cur_ff, prev_ff, head_rd_ff;
   logic [NW:0]   steps_ff;
   logic [63:0] rlo_ff, rhi_ff;
   logic [4:0]  rlen_ff;
   logic [31:0] rval_ff;
   logic [NW-1:0] rlnk_ff;
   logic [PW-1:0] scan_ff;
   logic [BW-1:0] clr_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     res_ff;

   logic [4:0]  len_c;
   logic [63:0] lo_c, hi_c, mlo, mhi;
   logic [6:0]  mod_c;
   logic [7:0]  byte_c;

   always_comb begin
      len_c = (req.payload.key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES)
                                                           : req.payload.key_length;
      mlo = '0;
      mhi = '0;
      for (int i = 0; i < 8; i++) begin
         if (5'(i) < len_c) mlo[i*8 +: 8] = 8'hFF;
         if (5'(i + 8) < len_c) mhi[i*8 +: 8] = 8'hFF;
      end
      lo_c = req.payload.key_low & mlo;
      hi_c = req.payload.key_high & mhi;
      mod_c = (bcnt_ff == 7'd0) ? 7'd1 : bcnt_ff;
      if (int'(mod_c) > NUM_BUCKETS) mod_c = 7'(NUM_BUCKETS);
      byte_c = idx_ff[3] ? hi_ff[idx_ff[2:0]*8 +: 8] : lo_ff[idx_ff[2:0]*8 +: 8];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) bcnt_ff <= BucketCountReset;
      else if (csr_write_enable) bcnt_ff <= csr_write_data;
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= heads[bkt_ff];
      rlo_ff  <= n_lo[cur_ff[PW-1:0]];
      rhi_ff  <= n_hi[cur_ff[PW-1:0]];
      rlen_ff <= n_len[cur_ff[PW-1:0]];
      rval_ff <= n_val[cur_ff[PW-1:0]];
      rlnk_ff <= n_lnk[cur_ff[PW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         free_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLR: begin
               heads[clr_ff] <= NoNode;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(NUM_BUCKETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  op_ff <= req.payload.req_type;
                  lo_ff <= lo_c;
                  hi_ff <= hi_c;
                  len_ff <= len_c;
                  val_ff <= req.payload.value_in;
                  mod_ff <= HW'(mod_c);
                  h_ff <= '0;
                  idx_ff <= '0;
                  state_ff <= (len_c == 5'd0) ? S_HEAD : S_MUL;
               end
            end
            S_MUL: begin
               h_ff <= MW'({h_ff[HW-1:0], 5'd0}) + MW'(h_ff[HW-1:0]) + MW'(byte_c);
               idx_ff <= idx_ff + 5'd1;
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (h_ff >= MW'({mod_ff, 5'd0})) h_ff <= h_ff - MW'({mod_ff, 5'd0});
               else if (h_ff >= MW'(mod_ff)) h_ff <= h_ff - MW'(mod_ff);
               else state_ff <= (idx_ff == len_ff) ? S_HEAD : S_MUL;
            end
            S_HEAD: begin
               bkt_ff <= BW'(h_ff);
               scan_ff <= '0;
               steps_ff <= '0;
               prev_ff <= NoNode;
               state_ff <= (op_ff == OP_INSERT) ? S_SCAN : S_HEADW;
            end
            S_HEADW: begin
               state_ff <= S_HEADR;
            end
            S_HEADR: begin
               cur_ff <= head_rd_ff;
               state_ff <= S_NODE;
            end
            S_NODE: begin
               if (cur_ff >= NoNode || steps_ff >= (NW+1)'(POOL_ENTRIES)) begin
                  res_ff.status <= ST_NOT_FOUND;
                  res_ff.value_out <= (op_ff == OP_ACCESS) ? -32'sd1 : 32'sd0;
                  state_ff <= S_OUT;
               end else state_ff <= S_CMP;
            end
            S_CMP: begin
               if (rlen_ff == len_ff && rlo_ff == lo_ff && rhi_ff == hi_ff) begin
                  res_ff.status <= ST_DONE;
                  res_ff.value_out <= (op_ff == OP_ACCESS) ? rval_ff : 32'sd0;
                  state_ff <= (op_ff == OP_DELETE) ? S_DEL : S_OUT;
                  if (op_ff == OP_UPDATE) n_val[cur_ff[PW-1:0]] <= val_ff;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff <= rlnk_ff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_NODE;
               end
            end
            S_DEL: begin
               if (prev_ff == NoNode) heads[bkt_ff] <= rlnk_ff;
               else n_lnk[prev_ff[PW-1:0]] <= rlnk_ff;
               free_ff[cur_ff[PW-1:0]] <= 1'b1;
               state_ff <= S_OUT;
            end
            S_SCAN: begin
               if (free_ff[scan_ff]) begin
                  cur_ff <= NW'(scan_ff);
                  state_ff <= S_INS;
               end else if (scan_ff == PW'(POOL_ENTRIES - 1)) begin
                  res_ff.status <= ST_FULL;
                  res_ff.value_out <= 32'sd0;
                  state_ff <= S_OUT;
               end else scan_ff <= scan_ff + 1'b1;
            end
            S_INS: begin
               free_ff[cur_ff[PW-1:0]] <= 1'b0;
               n_lo[cur_ff[PW-1:0]] <= lo_ff;
               n_hi[cur_ff[PW-1:0]] <= hi_ff;
               n_len[cur_ff[PW-1:0]] <= len_ff;
               n_val[cur_ff[PW-1:0]] <= val_ff;
               n_lnk[cur_ff[PW-1:0]] <= head_rd_ff;
               heads[bkt_ff] <= cur_ff;
               res_ff.status <= ST_DONE;
               res_ff.value_out <= 32'sd0;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== bench/tb_chained_hash_table_engine_top.sv =====
// Testbench: random and directed table operations checked against a behavioral hash table.
`timescale 1ns / 100ps
module tb_chained_hash_table_engine_top;
   import cht_pkg::*;

   localparam int NB = 64;
   localparam int NP = 64;
   localparam int NO_NODE = NP;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [6:0] csr_write_data = 7'd0;

   cht_req_if req_ch ();
   cht_rsp_if rsp_ch ();

   chained_hash_table_engine_top dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // table image
   int unsigned modulus_reg;
   int heads [NB];
   logic [63:0] nlo [NP];
   logic [63:0] nhi [NP];
   int nlen [NP];
   logic [31:0] nval [NP];
   int nlink [NP];
   bit nfree [NP];

   req_type_type pending_reqs[$];
   rsp_type expected_rsps[$];
   req_type_type key_pool[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int fail_count = 0;
   int rsp_count = 0;
   int req_count = 0;
   int stall_count = 0;
   int idle_cycles = 0;
   int status_seen [3];
   bit req_taken = 1'b0;

   function automatic void table_reset();
      modulus_reg = 53;
      for (int i = 0; i < NB; i++) heads[i] = NO_NODE;
      for (int i = 0; i < NP; i++) begin
         nlink[i] = NO_NODE;
         nfree[i] = 1'b1;
      end
   endfunction

   function automatic rsp_type table_apply(req_type_type r);
      rsp_type o;
      int unsigned m;
      int unsigned h;
      int len;
      int b;
      int cur;
      int prev;
      int steps;
      int n;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [7:0] by;
      o.status = ST_DONE;
      o.value_out = 0;
      m = modulus_reg;
      if (m == 0) m = 1;
      if (m > NB) m = NB;
      len = int'(r.key_length);
      if (len > 16) len = 16;
      lo = (len >= 8) ? r.key_low : (r.key_low & ((64'd1 << (8 * len)) - 1));
      hi = (len <= 8) ? 64'd0 : (len >= 16) ? r.key_high :
           (r.key_high & ((64'd1 << (8 * (len - 8))) - 1));
      h = 0;
      for (int i = 0; i < len; i++) begin
         by = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
         h = (h * 33 + by) % m;
      end
      b = h;
      if (r.req_type == OP_INSERT) begin
         n = NO_NODE;
         for (int i = 0; i < NP; i++) if (nfree[i] && n == NO_NODE) n = i;
         if (n == NO_NODE) o.status = ST_FULL;
         else begin
            nfree[n] = 1'b0;
            nlo[n] = lo;
            nhi[n] = hi;
            nlen[n] = len;
            nval[n] = r.value_in;
            nlink[n] = heads[b];
            heads[b] = n;
         end
      end else begin
         cur = heads[b];
         prev = NO_NODE;
         steps = 0;
         while (cur < NO_NODE && steps < NP &&
                !(nlen[cur] == len && nlo[cur] == lo && nhi[cur] == hi)) begin
            prev = cur;
            cur = nlink[cur];
            steps++;
         end
         if (cur >= NO_NODE || steps >= NP) begin
            o.status = ST_NOT_FOUND;
            if (r.req_type == OP_ACCESS) o.value_out = -1;
         end else if (r.req_type == OP_DELETE) begin
            if (prev == NO_NODE) heads[b] = nlink[cur];
            else nlink[prev] = nlink[cur];
            nlink[cur] = NO_NODE;
            nfree[cur] = 1'b1;
         end else if (r.req_type == OP_UPDATE) nval[cur] = r.value_in;
         else o.value_out = nval[cur];
      end
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.payload <= pending_reqs.pop_front();
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver ready with optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(table_apply(req_ch.payload));
            req_count++;
         end
         if (req_ch.valid && !req_ch.ready) stall_count++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected beat status=%0d value=%0d", $time,
                        rsp_ch.payload.status, rsp_ch.payload.value_out);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_ch.payload.status < 3) status_seen[rsp_ch.payload.status]++;
               if (e.status !== rsp_ch.payload.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_ch.payload.status);
                  fail_count++;
               end
               if (e.value_out !== rsp_ch.payload.value_out) begin
                  $display("%0t: value expected %0d actual %0d", $time, e.value_out,
                           rsp_ch.payload.value_out);
                  fail_count++;
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic req_type_type make_req(logic [1:0] op, logic [63:0] lo,
                                             logic [63:0] hi, logic [4:0] len,
                                             logic [31:0] v);
      req_type_type r;
      r.req_type = op;
      r.key_low = lo;
      r.key_high = hi;
      r.key_length = len;
      r.value_in = v;
      return r;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random key, biased to short keys and small alphabets so chains collide
   function automatic req_type_type rand_key();
      req_type_type r;
      int kind;
      kind = $urandom_range(9);
      r.key_low = rand64();
      r.key_high = rand64();
      if (kind < 4) begin
         r.key_length = 5'($urandom_range(3));
         r.key_low = r.key_low & 64'h0303_0303_0303_0303;
      end else r.key_length = 5'($urandom_range(31));
      r.req_type = OP_INSERT;
      r.value_in = $urandom;
      return r;
   endfunction

   task automatic drain(int tail);
      while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_modulus(logic [6:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      modulus_reg = 32'(v);
   endtask

   task automatic random_phase(int count);
      req_type_type r;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (key_pool.size() > 0 && pick < 60) begin
            r = key_pool[$urandom_range(key_pool.size() - 1)];
            r.req_type = 2'($urandom_range(1, 3));
            r.value_in = $urandom;
            if ($urandom_range(3) == 0) r.req_type = OP_INSERT;
            // garble the bits past the length (all of key_high when shorter than 16 bytes); the former must not matter
            if ($urandom_range(3) == 0) begin
               if (r.key_length < 8)
                  r.key_low = r.key_low | (rand64() << (8 * r.key_length));
               if (r.key_length < 16) r.key_high = r.key_high | rand64();
            end
         end else begin
            r = rand_key();
            r.req_type = (pick < 85) ? OP_INSERT : 2'($urandom_range(3));
            if (r.req_type == OP_INSERT) begin
               key_pool.push_back(r);
               if (key_pool.size() > 40) void'(key_pool.pop_front());
            end
         end
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      table_reset();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, empty key, overlong length
      pending_reqs.push_back(make_req(OP_ACCESS, '0, '0, 5'd0, '0));
      pending_reqs.push_back(make_req(OP_INSERT, '0, '0, 5'd0, 32'h8000_0000));
      pending_reqs.push_back(make_req(OP_ACCESS, '1, '1, 5'd0, '0));
      pending_reqs.push_back(make_req(OP_INSERT, '1, '1, 5'd31, 32'h7fff_ffff));
      pending_reqs.push_back(make_req(OP_ACCESS, '1, '1, 5'd16, '0));
      pending_reqs.push_back(make_req(OP_UPDATE, '1, '1, 5'd16, 32'hffff_ffff));
      pending_reqs.push_back(make_req(OP_ACCESS, '1, '1, 5'd20, '0));
      pending_reqs.push_back(make_req(OP_INSERT, 64'h00ff, '1, 5'd1, 32'd5));
      pending_reqs.push_back(make_req(OP_ACCESS, 64'hab_ff, '0, 5'd1, '0));
      pending_reqs.push_back(make_req(OP_DELETE, 64'hff, '0, 5'd1, '0));
      pending_reqs.push_back(make_req(OP_DELETE, 64'hff, '0, 5'd1, '0));
      pending_reqs.push_back(make_req(OP_UPDATE, 64'h12, '0, 5'd2, 32'd1));
      pending_reqs.push_back(make_req(OP_DELETE, '0, '0, 5'd0, '0));
      pending_reqs.push_back(make_req(OP_ACCESS, '0, '0, 5'd0, '0));
      drain(10);

      // fill the pool to overflow with the receiver held off
      hold_cycles = 3000;
      for (int i = 0; i < 66; i++)
         pending_reqs.push_back(make_req(OP_INSERT, 64'(i), 64'h0, 5'd1, 32'(i)));
      pending_reqs.push_back(make_req(OP_ACCESS, 64'd7, '0, 5'd1, '0));
      drain(10);
      for (int i = 0; i < 64; i++)
         pending_reqs.push_back(make_req(OP_DELETE, 64'(i), 64'h0, 5'd1, '0));
      drain(300);

      // three pacing phases over several modulus settings
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 86 : 0;
         recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 7 : 0;
         for (int s = 0; s < 3; s++) begin
            case (s)
               0: write_modulus((ph == 0) ? 7'd1 : (ph == 1) ? 7'd64 : 7'd0);
               1: write_modulus((ph == 2) ? 7'd127 : 7'($urandom_range(2, 63)));
               default: write_modulus(7'($urandom_range(127)));
            endcase
            random_phase(200);
            drain(300);
         end
      end

      $display("Checked %0d requests and %0d responses (done %0d, not found %0d, full %0d).",
               req_count, rsp_count, status_seen[0], status_seen[1], status_seen[2]);
      $display("Request stalls observed: %0d cycles.", stall_count);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
